// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way run merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;
    localparam int WAYS_DEF        = 64;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int VAL_W           = 32;
    localparam int SRC_W           = 6;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REFILL = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [SRC_W-1:0] source;
        logic [VAL_W-1:0] value;
        logic [31:0]      run_length;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] out_value;
        logic [SRC_W-1:0] out_source;
        logic             refill_request;
        logic             last;
        logic             empty_error;
    } out_item_t;

    // a strictly before b: signed value, ties to lower source
    function automatic logic ent_before(input logic [VAL_W-1:0] av, input logic [SRC_W-1:0] as_,
                                        input logic [VAL_W-1:0] bv, input logic [SRC_W-1:0] bs);
        if (av != bv)
            return $signed(av) < $signed(bv);
        return as_ < bs;
    endfunction
endpackage

// ===== rtl/core/kwm_stream_if.sv =====
// ----------------------------------------------------------------------------
// kwm_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface kwm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/kwm_heap_mem.sv =====
// ----------------------------------------------------------------------------
// kwm_heap_mem
// Heap entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kwm_heap_mem #(
    parameter int DEPTH = kwm_pkg::WAYS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [kwm_pkg::VAL_W+kwm_pkg::SRC_W-1:0] wdata,
    input  logic [AW-1:0]                raddr_a,
    input  logic [AW-1:0]                raddr_b,
    output logic [kwm_pkg::VAL_W+kwm_pkg::SRC_W-1:0] rdata_a,
    output logic [kwm_pkg::VAL_W+kwm_pkg::SRC_W-1:0] rdata_b
);
    logic [kwm_pkg::VAL_W+kwm_pkg::SRC_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== rtl/core/kwm_count_mem.sv =====
// ----------------------------------------------------------------------------
// kwm_count_mem
// Remaining-length store per source, registered read.
// ----------------------------------------------------------------------------
module kwm_count_mem #(
    parameter int DEPTH = kwm_pkg::WAYS_DEF,
    parameter int LW    = kwm_pkg::LENGTH_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [LW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [LW-1:0] rdata
);
    logic [LW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/k_way_run_merge_core.sv =====
// ----------------------------------------------------------------------------
// k_way_run_merge_core
// Min-heap k-way merge engine over two synchronous memories.
// ----------------------------------------------------------------------------
// Steps: load/refill writes the new entry and sifts it up level by level; a pop
// reads root and last entry, sifts down level by level, then emits; an empty pop answers from idle.
// One request at a time; the heap sift loop, one read-compare-write per level
// through the heap memory, sets the rate.
// Result sits in an output register; loads and refills are taken meanwhile.
// Reset clears heap count, pending source and control; memories hold no reset.
`include "assert_macros.svh"
module k_way_run_merge_core #(
    parameter int WAYS        = kwm_pkg::WAYS_DEF,
    parameter int LENGTH_BITS = kwm_pkg::LENGTH_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kwm_stream_if.sink   in_ch,
    kwm_stream_if.source out_ch
);
    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(WAYS + 1);
    localparam int EW = kwm_pkg::VAL_W + kwm_pkg::SRC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH_RD, S_PUSH_CMP, S_POP_RD, S_POP_LAST, S_POP_CNT,
        S_SIFT_RD, S_SIFT_CMP, S_EMIT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [kwm_pkg::SRC_W-1:0] pending_reg;
    logic [AW-1:0] idx_reg;
    logic [EW-1:0] ent_reg;
    logic [EW-1:0] top_reg;
    logic [kwm_pkg::SRC_W-1:0] pop_src_reg;
    kwm_pkg::out_item_t out_reg;
    logic out_valid_reg;

    logic hm_we;
    logic [AW-1:0] hm_waddr, hm_ra, hm_rb;
    logic [EW-1:0] hm_wdata, hm_da, hm_db;
    logic cm_we;
    logic [AW-1:0] cm_waddr, cm_raddr;
    logic [LENGTH_BITS-1:0] cm_wdata, cm_rdata;

    kwm_heap_mem #(.DEPTH(WAYS), .AW(AW)) u_heap (
        .clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
        .raddr_a(hm_ra), .raddr_b(hm_rb), .rdata_a(hm_da), .rdata_b(hm_db));

    kwm_count_mem #(.DEPTH(WAYS), .LW(LENGTH_BITS), .AW(AW)) u_cnt (
        .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
        .raddr(cm_raddr), .rdata(cm_rdata));

    kwm_pkg::in_item_t req;
    assign req = in_ch.data;
    // a pop waits until the previous result has left the output register
    assign in_ch.ready = (state_reg == S_IDLE)
                         && !(out_valid_reg && req.mode == kwm_pkg::MODE_POP);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
    wire accept = in_ch.valid && in_ch.ready;

    // saturated run length
    logic [LENGTH_BITS-1:0] len_sat;
    always_comb
    begin
        if (LENGTH_BITS >= 32)
            len_sat = LENGTH_BITS'(req.run_length);
        else if ((req.run_length >> LENGTH_BITS) != 32'd0)
            len_sat = '1;
        else
            len_sat = LENGTH_BITS'(req.run_length);
    end
    wire src_ok = ({26'd0, req.source} < 32'(WAYS));
    wire full = (count_reg >= CW'(WAYS));

    // child indexes of idx_reg
    logic [AW+1:0] lidx, ridx;
    assign lidx = {1'b0, idx_reg, 1'b1};
    assign ridx = lidx + (AW+2)'(1);
    wire l_ok = lidx < (AW+2)'(count_reg);
    wire r_ok = ridx < (AW+2)'(count_reg);
    wire [AW-1:0] parent = AW'((idx_reg - AW'(1)) >> 1);

    // sift-down choice
    logic [EW-1:0] best;
    logic best_l, best_r;
    always_comb
    begin
        best = ent_reg; best_l = 1'b0; best_r = 1'b0;
        if (l_ok && kwm_pkg::ent_before(hm_da[EW-1 -: kwm_pkg::VAL_W],
                hm_da[kwm_pkg::SRC_W-1:0], best[EW-1 -: kwm_pkg::VAL_W],
                best[kwm_pkg::SRC_W-1:0]))
        begin
            best = hm_da; best_l = 1'b1;
        end
        if (r_ok && kwm_pkg::ent_before(hm_db[EW-1 -: kwm_pkg::VAL_W],
                hm_db[kwm_pkg::SRC_W-1:0], best[EW-1 -: kwm_pkg::VAL_W],
                best[kwm_pkg::SRC_W-1:0]))
        begin
            best = hm_db; best_l = 1'b0; best_r = 1'b1;
        end
    end
    wire up_swap = kwm_pkg::ent_before(ent_reg[EW-1 -: kwm_pkg::VAL_W],
        ent_reg[kwm_pkg::SRC_W-1:0], hm_da[EW-1 -: kwm_pkg::VAL_W],
        hm_da[kwm_pkg::SRC_W-1:0]);

    always_comb
    begin
        hm_we = 1'b0; hm_waddr = idx_reg; hm_wdata = ent_reg;
        hm_ra = '0; hm_rb = '0;
        cm_we = 1'b0; cm_waddr = AW'(req.source); cm_wdata = len_sat - LENGTH_BITS'(1);
        cm_raddr = AW'(pop_src_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.mode == kwm_pkg::MODE_LOAD && src_ok)
                begin
                    if (len_sat == '0)
                    begin
                        cm_we = 1'b1; cm_wdata = '0;
                    end
                    else if (!full)
                        cm_we = 1'b1;
                end
                hm_ra = '0;
            end
            S_PUSH_RD: hm_ra = parent;
            S_PUSH_CMP:
            begin
                hm_we = 1'b1;
                hm_wdata = (idx_reg != '0 && up_swap) ? hm_da : ent_reg;
            end
            S_POP_RD: hm_ra = AW'(count_reg);
            S_POP_CNT:
            begin
                cm_raddr = AW'(pop_src_reg);
            end
            S_SIFT_RD:
            begin
                hm_ra = lidx[AW-1:0];
                hm_rb = ridx[AW-1:0];
            end
            S_SIFT_CMP:
            begin
                hm_we = 1'b1;
                hm_wdata = best;
            end
            S_EMIT:
            begin
                if (cm_rdata != '0)
                begin
                    cm_we = 1'b1; cm_waddr = AW'(pop_src_reg);
                    cm_wdata = cm_rdata - LENGTH_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pending_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            ent_reg <= '0;
            top_reg <= '0;
            pop_src_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ent_reg <= {req.value, (req.mode == kwm_pkg::MODE_REFILL)
                                    ? pending_reg : req.source};
                        idx_reg <= AW'(count_reg);
                        if ((req.mode == kwm_pkg::MODE_LOAD && src_ok && len_sat != '0
                             && !full) || (req.mode == kwm_pkg::MODE_REFILL && !full))
                        begin
                            count_reg <= count_reg + CW'(1);
                            state_reg <= S_PUSH_RD;
                        end
                        else if (req.mode == kwm_pkg::MODE_POP)
                        begin
                            if (count_reg == '0)
                            begin
                                out_reg <= '{out_value: '0, out_source: '0,
                                    refill_request: 1'b0, last: 1'b0, empty_error: 1'b1};
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg - CW'(1);
                                state_reg <= S_POP_RD;
                            end
                        end
                    end
                end
                S_PUSH_RD: state_reg <= S_PUSH_CMP;
                S_PUSH_CMP:
                begin
                    if (idx_reg != '0 && up_swap)
                    begin
                        idx_reg <= parent;
                        state_reg <= S_PUSH_RD;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_POP_RD:
                begin
                    // hm_da holds the root
                    top_reg <= hm_da;
                    pop_src_reg <= hm_da[kwm_pkg::SRC_W-1:0];
                    state_reg <= S_POP_LAST;
                end
                S_POP_LAST:
                begin
                    ent_reg <= hm_da;
                    idx_reg <= '0;
                    state_reg <= S_POP_CNT;
                end
                S_POP_CNT:
                begin
                    state_reg <= (count_reg == '0) ? S_EMIT : S_SIFT_RD;
                end
                S_SIFT_RD: state_reg <= S_SIFT_CMP;
                S_SIFT_CMP:
                begin
                    if (best_l || best_r)
                    begin
                        idx_reg <= best_l ? lidx[AW-1:0] : ridx[AW-1:0];
                        state_reg <= S_SIFT_RD;
                    end
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (cm_rdata != '0)
                        pending_reg <= pop_src_reg;
                    out_reg <= '{out_value: top_reg[EW-1 -: kwm_pkg::VAL_W],
                        out_source: pop_src_reg, refill_request: (cm_rdata != '0),
                        last: (count_reg == '0) && (cm_rdata == '0), empty_error: 1'b0};
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the sift writes ent_reg or child at idx, then moves on; child slot is rewritten next level
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == S_IDLE)
    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(WAYS))
    `ASSERT_NEXT(a_emit_valid, clk, rst_n, state_reg == S_EMIT, out_valid_reg)
endmodule
